// ===== rtl/wspd_pkg.sv =====
// Shared types, constants and register map of the wheel speed PI drive.
package wspd_pkg;

    // Default plant constants handed to the top level as parameter defaults.
    localparam int unsigned PULSES_PER_REV_DEF   = 28;
    localparam int unsigned TICKS_PER_SECOND_DEF = 50;

    // Field widths.
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned TARGET_W = 16;
    localparam int unsigned SPEED_W = 23;
    localparam int unsigned DRIVE_W = 16;
    localparam int unsigned CHAN_W = 15;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned LIMIT_W = 15;

    // Gains are unsigned Q4.12.
    localparam int unsigned FRAC_BITS = 12;

    // Configuration port.
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  KP_GAIN_RST     = 16'd410;
    localparam logic [GAIN_W-1:0]  KI_GAIN_RST     = 16'd205;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd5000;
    localparam logic               SWAP_RST        = 1'b0;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_KP_GAIN       = 2'd0,
        REG_KI_GAIN       = 2'd1,
        REG_DRIVE_LIMIT   = 2'd2,
        REG_SWAP_CHANNELS = 2'd3
    } t_reg_idx;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0]  kp_gain;
        logic [GAIN_W-1:0]  ki_gain;
        logic [LIMIT_W-1:0] drive_limit;
        logic               swap_channels;
    } t_cfg;

endpackage

// ===== rtl/wspd_cfg.sv =====
// Configuration register file with its APB-style write and read port.
module wspd_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wspd_pkg::ADDR_W-1:0] paddr,
    input  logic [wspd_pkg::DATA_W-1:0] pwdata,
    output logic [wspd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output wspd_pkg::t_cfg              o_cfg
);

    wspd_pkg::t_cfg     r_cfg;
    wspd_pkg::t_reg_idx w_idx;
    logic               w_write;

    assign pready  = 1'b1;
    assign w_idx   = wspd_pkg::t_reg_idx'(paddr[wspd_pkg::ADDR_W-1:2]);
    assign w_write = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    // Register writes during the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain       <= wspd_pkg::KP_GAIN_RST;
            r_cfg.ki_gain       <= wspd_pkg::KI_GAIN_RST;
            r_cfg.drive_limit   <= wspd_pkg::DRIVE_LIMIT_RST;
            r_cfg.swap_channels <= wspd_pkg::SWAP_RST;
        end else if (w_write) begin
            case (w_idx)
                wspd_pkg::REG_KP_GAIN: begin
                    r_cfg.kp_gain <= pwdata[wspd_pkg::GAIN_W-1:0];
                end
                wspd_pkg::REG_KI_GAIN: begin
                    r_cfg.ki_gain <= pwdata[wspd_pkg::GAIN_W-1:0];
                end
                wspd_pkg::REG_DRIVE_LIMIT: begin
                    r_cfg.drive_limit <= pwdata[wspd_pkg::LIMIT_W-1:0];
                end
                wspd_pkg::REG_SWAP_CHANNELS: begin
                    r_cfg.swap_channels <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data, zero-extended to the bus width.
    always_comb begin
        case (w_idx)
            wspd_pkg::REG_KP_GAIN:       prdata = wspd_pkg::DATA_W'(r_cfg.kp_gain);
            wspd_pkg::REG_KI_GAIN:       prdata = wspd_pkg::DATA_W'(r_cfg.ki_gain);
            wspd_pkg::REG_DRIVE_LIMIT:   prdata = wspd_pkg::DATA_W'(r_cfg.drive_limit);
            wspd_pkg::REG_SWAP_CHANNELS: prdata = wspd_pkg::DATA_W'(r_cfg.swap_channels);
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== rtl/wspd_speed.sv =====
// Input stage: converts the encoder pulse count to a wheel speed in rpm.
module wspd_speed #(
    parameter int unsigned PULSES_PER_REV   = wspd_pkg::PULSES_PER_REV_DEF,
    parameter int unsigned TICKS_PER_SECOND = wspd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wspd_pkg::COUNT_W-1:0]  i_pulse_count,
    input  logic signed [wspd_pkg::TARGET_W-1:0] i_target_speed,
    input  logic                                 i_advance,
    output logic                                 o_valid,
    output logic signed [wspd_pkg::SPEED_W-1:0]  o_speed,
    output logic signed [wspd_pkg::TARGET_W-1:0] o_target
);

    // rpm = count * TICKS_PER_SECOND * 60 / PULSES_PER_REV, done as a multiply by a
    // rounded-up reciprocal. The shift gives at least 2^16 * PULSES_PER_REV of
    // headroom, so the truncated quotient is exact for any 16-bit magnitude.
    localparam longint unsigned RPM_SCALE = longint'(TICKS_PER_SECOND) * 60;
    localparam int unsigned     SHIFT     = 16 + $clog2(PULSES_PER_REV);
    localparam longint unsigned RECIP     =
        ((RPM_SCALE << SHIFT) + longint'(PULSES_PER_REV) - 1) / longint'(PULSES_PER_REV);
    localparam int unsigned     RECIP_W   = $clog2(RECIP + 1);
    localparam int unsigned     PROD_W    = wspd_pkg::COUNT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic                                 r_valid;
    logic signed [wspd_pkg::SPEED_W-1:0]  r_speed;
    logic signed [wspd_pkg::TARGET_W-1:0] r_target;
    logic                                 w_load;
    logic                                 w_neg;
    logic [wspd_pkg::COUNT_W-1:0]         w_mag;
    logic [PROD_W-1:0]                    w_prod;
    logic [31:0]                          w_quot;
    logic [wspd_pkg::SPEED_W-1:0]         w_speed;

    assign o_in_stall = r_valid && !i_advance;
    assign w_load     = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_speed    = r_speed;
    assign o_target   = r_target;

    // Magnitude times reciprocal, then the sign back; the result wraps to 23 bits.
    always_comb begin
        w_neg   = i_pulse_count[wspd_pkg::COUNT_W-1];
        w_mag   = w_neg ? wspd_pkg::COUNT_W'(-i_pulse_count)
                        : wspd_pkg::COUNT_W'(i_pulse_count);
        w_prod  = PROD_W'(w_mag) * PROD_W'(RECIP_K);
        w_quot  = 32'(w_prod >> SHIFT);
        w_speed = w_neg ? wspd_pkg::SPEED_W'(-w_quot) : wspd_pkg::SPEED_W'(w_quot);
    end

    // Stage valid: set on a new transaction, cleared when the PI stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_speed  <= signed'(w_speed);
            r_target <= i_target_speed;
        end
    end

endmodule

// ===== rtl/wspd_pi.sv =====
// PI stage: incremental PI update, saturation, PWM channel mapping and result register.
module wspd_pi (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wspd_pkg::t_cfg                       i_cfg,
    input  logic                                 i_valid,
    input  logic signed [wspd_pkg::SPEED_W-1:0]  i_speed,
    input  logic signed [wspd_pkg::TARGET_W-1:0] i_target,
    output logic                                 o_advance,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [wspd_pkg::DRIVE_W-1:0]  o_drive_value,
    output logic [wspd_pkg::CHAN_W-1:0]          o_channel_a,
    output logic [wspd_pkg::CHAN_W-1:0]          o_channel_b,
    output logic signed [wspd_pkg::SPEED_W-1:0]  o_measured_speed
);

    localparam int unsigned DERR_W = wspd_pkg::SPEED_W + 1;
    localparam int unsigned PT_W   = wspd_pkg::GAIN_W + 1 + DERR_W;
    localparam int unsigned IT_W   = wspd_pkg::GAIN_W + 1 + wspd_pkg::SPEED_W;
    localparam int unsigned ACC_W  = wspd_pkg::DRIVE_W + wspd_pkg::FRAC_BITS;
    localparam int unsigned SUM_W  = PT_W + 1;
    localparam int unsigned QUOT_W = SUM_W - wspd_pkg::FRAC_BITS;
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << wspd_pkg::FRAC_BITS) - 1);

    logic                                r_out_valid;
    logic signed [wspd_pkg::DRIVE_W-1:0] r_drive_acc;
    logic signed [wspd_pkg::SPEED_W-1:0] r_prev_error;
    logic signed [wspd_pkg::DRIVE_W-1:0] r_drive_value;
    logic [wspd_pkg::CHAN_W-1:0]         r_channel_a;
    logic [wspd_pkg::CHAN_W-1:0]         r_channel_b;
    logic signed [wspd_pkg::SPEED_W-1:0] r_speed;

    logic signed [DERR_W-1:0]            w_err_full;
    logic signed [wspd_pkg::SPEED_W-1:0] w_err;
    logic signed [DERR_W-1:0]            w_derr;
    logic signed [wspd_pkg::GAIN_W:0]    w_kp;
    logic signed [wspd_pkg::GAIN_W:0]    w_ki;
    logic signed [PT_W-1:0]              w_p_term;
    logic signed [IT_W-1:0]              w_i_term;
    logic signed [ACC_W-1:0]             w_acc_scaled;
    logic signed [SUM_W-1:0]             w_sum;
    logic signed [SUM_W-1:0]             w_biased;
    logic signed [QUOT_W-1:0]            w_quot;
    logic signed [QUOT_W-1:0]            w_lim;
    logic signed [wspd_pkg::DRIVE_W-1:0] w_drive;
    logic [wspd_pkg::CHAN_W-1:0]         w_mag;
    logic [wspd_pkg::CHAN_W-1:0]         w_fwd;
    logic [wspd_pkg::CHAN_W-1:0]         w_rev;

    // The stage moves when a speed is waiting and the result register is free.
    assign o_advance        = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid      = r_out_valid;
    assign o_drive_value    = r_drive_value;
    assign o_channel_a      = r_channel_a;
    assign o_channel_b      = r_channel_b;
    assign o_measured_speed = r_speed;

    // Error terms and the scaled increment.
    always_comb begin
        w_err_full   = DERR_W'(i_target) - DERR_W'(i_speed);
        w_err        = w_err_full[wspd_pkg::SPEED_W-1:0];
        w_derr       = DERR_W'(w_err) - DERR_W'(r_prev_error);
        w_kp         = signed'({1'b0, i_cfg.kp_gain});
        w_ki         = signed'({1'b0, i_cfg.ki_gain});
        w_p_term     = PT_W'(w_kp) * PT_W'(w_derr);
        w_i_term     = IT_W'(w_ki) * IT_W'(w_err);
        w_acc_scaled = signed'({r_drive_acc, {wspd_pkg::FRAC_BITS{1'b0}}});
        w_sum        = SUM_W'(w_p_term) + SUM_W'(w_i_term) + SUM_W'(w_acc_scaled);
    end

    // Truncate toward zero, force zero on a zero target, then saturate.
    always_comb begin
        w_biased = w_sum[SUM_W-1] ? (w_sum + signed'(ROUND_BIAS)) : w_sum;
        w_quot   = w_biased[SUM_W-1:wspd_pkg::FRAC_BITS];
        w_lim    = signed'(QUOT_W'(i_cfg.drive_limit));
        if (i_target == '0) begin
            w_drive = '0;
        end else if (w_quot > w_lim) begin
            w_drive = wspd_pkg::DRIVE_W'(w_lim);
        end else if (w_quot < -w_lim) begin
            w_drive = wspd_pkg::DRIVE_W'(-w_lim);
        end else begin
            w_drive = wspd_pkg::DRIVE_W'(w_quot);
        end
    end

    // Magnitude goes on the forward or reverse channel; zero drive leaves both at zero.
    always_comb begin
        w_mag = w_drive[wspd_pkg::DRIVE_W-1] ? wspd_pkg::CHAN_W'(-w_drive)
                                             : wspd_pkg::CHAN_W'(w_drive);
        w_fwd = w_drive[wspd_pkg::DRIVE_W-1] ? '0 : w_mag;
        w_rev = w_drive[wspd_pkg::DRIVE_W-1] ? w_mag : '0;
    end

    // Result valid and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_drive_acc  <= '0;
            r_prev_error <= '0;
        end else begin
            if (o_advance) begin
                r_out_valid  <= 1'b1;
                r_drive_acc  <= w_drive;
                r_prev_error <= w_err;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_drive_value <= w_drive;
            r_channel_a   <= i_cfg.swap_channels ? w_rev : w_fwd;
            r_channel_b   <= i_cfg.swap_channels ? w_fwd : w_rev;
            r_speed       <= i_speed;
        end
    end

endmodule

// ===== rtl/wheel_speed_pi_drive_top.sv =====
// Top level of the wheel speed PI drive: speed stage, PI stage and registers.
//
// Usage: each control tick presents an encoder pulse count and a target speed
// on the input channel (i_in_valid / o_in_stall). One result transaction per
// input appears on the output channel (o_out_valid / i_out_stall) with the new
// saturated drive value, the two PWM compare values and the measured speed.
// An accepted input passes through the speed register and then the result
// register. The reciprocal multiply that turns pulses into rpm sits ahead of the
// speed register, and the PI update, which holds the drive and previous error
// feedback, sits between that register and the result register. Throughput is
// one transaction per cycle while the receiver does not stall; the feedback
// closes within the PI stage, so consecutive ticks follow each other directly.
// While the receiver stalls, the result register holds its transaction and the
// speed stage takes at most one more input before o_in_stall rises.
// A synchronous reset (i_rst_n low) empties both stages, clears the stored drive
// and previous error, and loads the gain, limit and swap register defaults.
// The user must write the gains, limit and channel swap over the APB-style port
// only while no transaction is in flight; the block itself does not enforce this.
module wheel_speed_pi_drive_top #(
    parameter int unsigned PULSES_PER_REV   = wspd_pkg::PULSES_PER_REV_DEF,
    parameter int unsigned TICKS_PER_SECOND = wspd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wspd_pkg::COUNT_W-1:0]  i_pulse_count,
    input  logic signed [wspd_pkg::TARGET_W-1:0] i_target_speed,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [wspd_pkg::DRIVE_W-1:0]  o_drive_value,
    output logic [wspd_pkg::CHAN_W-1:0]          o_channel_a,
    output logic [wspd_pkg::CHAN_W-1:0]          o_channel_b,
    output logic signed [wspd_pkg::SPEED_W-1:0]  o_measured_speed,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wspd_pkg::ADDR_W-1:0]          paddr,
    input  logic [wspd_pkg::DATA_W-1:0]          pwdata,
    output logic [wspd_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    wspd_pkg::t_cfg                       w_cfg;
    logic                                 w_spd_valid;
    logic signed [wspd_pkg::SPEED_W-1:0]  w_spd_speed;
    logic signed [wspd_pkg::TARGET_W-1:0] w_spd_target;
    logic                                 w_advance;

    // Configuration registers.
    wspd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pulse count to rpm.
    wspd_speed #(
        .PULSES_PER_REV   (PULSES_PER_REV),
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_speed (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pulse_count  (i_pulse_count),
        .i_target_speed (i_target_speed),
        .i_advance      (w_advance),
        .o_valid        (w_spd_valid),
        .o_speed        (w_spd_speed),
        .o_target       (w_spd_target)
    );

    // PI update and output register.
    wspd_pi u_pi (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_valid          (w_spd_valid),
        .i_speed          (w_spd_speed),
        .i_target         (w_spd_target),
        .o_advance        (w_advance),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive_value    (o_drive_value),
        .o_channel_a      (o_channel_a),
        .o_channel_b      (o_channel_b),
        .o_measured_speed (o_measured_speed)
    );

endmodule

// ===== tb/sv/wspd_drive_checker.sv =====
// Checker for the wheel speed PI drive: tracks registers, predicts each result and compares it.
module wspd_drive_checker #(
    parameter int unsigned PULSES_PER_REV   = wspd_pkg::PULSES_PER_REV_DEF,
    parameter int unsigned TICKS_PER_SECOND = wspd_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [wspd_pkg::COUNT_W-1:0]  i_pulse_count,
    input  logic signed [wspd_pkg::TARGET_W-1:0] i_target_speed,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [wspd_pkg::DRIVE_W-1:0]  i_drive_value,
    input  logic [wspd_pkg::CHAN_W-1:0]          i_channel_a,
    input  logic [wspd_pkg::CHAN_W-1:0]          i_channel_b,
    input  logic signed [wspd_pkg::SPEED_W-1:0]  i_measured_speed,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [wspd_pkg::ADDR_W-1:0]          i_paddr,
    input  logic [wspd_pkg::DATA_W-1:0]          i_pwdata,
    input  logic [wspd_pkg::DATA_W-1:0]          i_prdata,
    input  logic                                 i_pready,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wspd_pkg::*;

    // One Q4.12 unit, the divisor of the PI sum.
    localparam longint GAIN_ONE = longint'(1) << FRAC_BITS;
    localparam int     SHOWN_FAILS = 10;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic [CHAN_W-1:0]         chan_a;
        logic [CHAN_W-1:0]         chan_b;
        logic signed [SPEED_W-1:0] speed;
    } t_drive_result;

    // Our own copy of the registers and of the controller state.
    logic [GAIN_W-1:0]         kp_gain;
    logic [GAIN_W-1:0]         ki_gain;
    logic [LIMIT_W-1:0]        drive_limit;
    logic                      swap_channels;
    logic signed [DRIVE_W-1:0] drive_acc;
    logic signed [SPEED_W-1:0] last_error;

    t_drive_result expected_drive_q[$];
    int            fail_count = 0;

    // Counts a failure and shows the first few of them.
    task automatic report_fail(input string what);
        fail_count++;
        if (fail_count <= SHOWN_FAILS) begin
            $display("%t wspd_drive_checker: %s", $realtime, what);
        end
    endtask

    // Works out the next drive result for one tick and advances the state.
    function automatic t_drive_result next_drive(
        input logic signed [COUNT_W-1:0]  count,
        input logic signed [TARGET_W-1:0] target
    );
        longint                    rpm_full;
        longint                    err_full;
        longint                    pi_sum;
        longint                    drv;
        longint                    lim;
        longint                    neg;
        logic signed [SPEED_W-1:0] rpm;
        logic signed [SPEED_W-1:0] err;
        logic [CHAN_W-1:0]         fwd;
        logic [CHAN_W-1:0]         rev;
        t_drive_result             res;

        // Speed in rpm, truncated toward zero and wrapped to the speed width.
        rpm_full = longint'(count) * longint'(TICKS_PER_SECOND) * 60
                 / longint'(PULSES_PER_REV);
        rpm = rpm_full[SPEED_W-1:0];
        err_full = longint'(target) - longint'(rpm);
        err = err_full[SPEED_W-1:0];

        // Incremental PI step; the whole sum is truncated toward zero.
        pi_sum = longint'(drive_acc) * GAIN_ONE
               + longint'(kp_gain) * (longint'(err) - longint'(last_error))
               + longint'(ki_gain) * longint'(err);
        drv = pi_sum / GAIN_ONE;
        last_error = err;

        // A zero target stops the wheel, then the limit applies.
        if (target == 0) begin
            drv = 0;
        end
        lim = longint'(drive_limit);
        if (drv < -lim) begin
            drv = -lim;
        end
        if (drv > lim) begin
            drv = lim;
        end
        drive_acc = drv[DRIVE_W-1:0];

        // The sign of the drive picks the channel that carries its magnitude.
        neg = -drv;
        fwd = (drv > 0) ? drv[CHAN_W-1:0] : '0;
        rev = (drv < 0) ? neg[CHAN_W-1:0] : '0;
        res.drive = drv[DRIVE_W-1:0];
        res.chan_a = swap_channels ? rev : fwd;
        res.chan_b = swap_channels ? fwd : rev;
        res.speed = rpm;
        return res;
    endfunction

    // Value a register read should return.
    function automatic logic [DATA_W-1:0] reg_readback(input t_reg_idx idx);
        logic [DATA_W-1:0] val;

        val = '0;
        case (idx)
            REG_KP_GAIN:       val[GAIN_W-1:0] = kp_gain;
            REG_KI_GAIN:       val[GAIN_W-1:0] = ki_gain;
            REG_DRIVE_LIMIT:   val[LIMIT_W-1:0] = drive_limit;
            REG_SWAP_CHANNELS: val[0] = swap_channels;
            default:           val = '0;
        endcase
        return val;
    endfunction

    // Watch the register port and both channels at every clock edge.
    always @(posedge i_clk) begin
        t_drive_result got;
        t_drive_result want;
        t_reg_idx      idx;

        if (!i_rst_n) begin
            kp_gain <= KP_GAIN_RST;
            ki_gain <= KI_GAIN_RST;
            drive_limit <= DRIVE_LIMIT_RST;
            swap_channels <= SWAP_RST;
            drive_acc = '0;
            last_error = '0;
            expected_drive_q.delete();
        end else begin
            // Register writes update our copy; reads must return it.
            idx = t_reg_idx'(i_paddr[3:2]);
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (idx)
                        REG_KP_GAIN:       kp_gain <= i_pwdata[GAIN_W-1:0];
                        REG_KI_GAIN:       ki_gain <= i_pwdata[GAIN_W-1:0];
                        REG_DRIVE_LIMIT:   drive_limit <= i_pwdata[LIMIT_W-1:0];
                        REG_SWAP_CHANNELS: swap_channels <= i_pwdata[0];
                        default:           ;
                    endcase
                end else if (i_prdata !== reg_readback(idx)) begin
                    report_fail($sformatf("register %s read 0x%0h, expected 0x%0h",
                        idx.name(), i_prdata, reg_readback(idx)));
                end
            end

            // A result transaction is checked against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got.drive = i_drive_value;
                got.chan_a = i_channel_a;
                got.chan_b = i_channel_b;
                got.speed = i_measured_speed;
                if (expected_drive_q.size() == 0) begin
                    report_fail($sformatf("result with no tick waiting: drive %0d",
                        got.drive));
                end else begin
                    want = expected_drive_q.pop_front();
                    if (got.drive !== want.drive || got.chan_a !== want.chan_a ||
                            got.chan_b !== want.chan_b || got.speed !== want.speed) begin
                        report_fail($sformatf({"mismatch (expected/actual): drive %0d/%0d ",
                            "chan_a %0d/%0d chan_b %0d/%0d speed %0d/%0d"},
                            want.drive, got.drive, want.chan_a, got.chan_a,
                            want.chan_b, got.chan_b, want.speed, got.speed));
                    end
                end
            end

            // Each accepted tick adds one prediction.
            if (i_in_valid && !i_in_stall) begin
                expected_drive_q.push_back(next_drive(i_pulse_count, i_target_speed));
            end
        end
        o_pending <= expected_drive_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/sv/tb_wheel_speed_pi_drive_top.sv =====
// Testbench top for the wheel speed PI drive: clock, reset, stimulus and verdict.
module tb_wheel_speed_pi_drive_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wspd_pkg::*;

    localparam int unsigned PPR         = PULSES_PER_REV_DEF;
    localparam int unsigned TPS         = TICKS_PER_SECOND_DEF;
    localparam int          IDLE_PCT    = 9;
    localparam int          HOLD_CYCLES = 80;
    localparam int          PHASE_TICKS = 246;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          CALM_FROM   = 400;
    localparam int          CALM_TO     = 560;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [COUNT_W-1:0]   i_pulse_count = '0;
    logic signed [TARGET_W-1:0]  i_target_speed = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]   o_drive_value;
    logic [CHAN_W-1:0]           o_channel_a;
    logic [CHAN_W-1:0]           o_channel_b;
    logic signed [SPEED_W-1:0]   o_measured_speed;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [DATA_W-1:0]           pwdata = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;

    int fail_count;
    int pending;
    int ticks_sent = 0;
    int results_seen = 0;

    wheel_speed_pi_drive_top #(
        .PULSES_PER_REV   (PPR),
        .TICKS_PER_SECOND (TPS)
    ) dut (.*);

    wspd_drive_checker #(
        .PULSES_PER_REV   (PPR),
        .TICKS_PER_SECOND (TPS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_pulse_count    (i_pulse_count),
        .i_target_speed   (i_target_speed),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_drive_value    (o_drive_value),
        .i_channel_a      (o_channel_a),
        .i_channel_b      (o_channel_b),
        .i_measured_speed (o_measured_speed),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_prdata         (prdata),
        .i_pready         (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 125 MHz clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Count completed result transactions; the receiver uses this to time its holds.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
        end
    end

    // Receiver: random stalls, a quiet window, and long holds that back the block up.
    initial begin
        int hold_left;
        int next_hold_at;

        hold_left = 0;
        next_hold_at = 100;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 700;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    initial begin
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                    psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_wheel_speed_pi_drive_top: done, errors");
        $finish;
    end

    // Offers one tick, with random idle cycles ahead of it, and waits for acceptance.
    task automatic send_tick(input logic signed [COUNT_W-1:0] count,
                             input logic signed [TARGET_W-1:0] target);
        while (!(ticks_sent >= CALM_FROM && ticks_sent < CALM_TO) &&
                $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pulse_count <= count;
        i_target_speed <= target;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transaction: setup cycle, access cycle, then a free cycle.
    task automatic reg_access(input t_reg_idx idx, input logic wr,
                              input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes all four registers, then reads them back for the checker.
    task automatic load_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [LIMIT_W-1:0] lim, input logic swap);
        reg_access(REG_KP_GAIN, 1'b1, DATA_W'(kp));
        reg_access(REG_KI_GAIN, 1'b1, DATA_W'(ki));
        reg_access(REG_DRIVE_LIMIT, 1'b1, DATA_W'(lim));
        reg_access(REG_SWAP_CHANNELS, 1'b1, DATA_W'(swap));
        reg_access(REG_KP_GAIN, 1'b0, '0);
        reg_access(REG_KI_GAIN, 1'b0, '0);
        reg_access(REG_DRIVE_LIMIT, 1'b0, '0);
        reg_access(REG_SWAP_CHANNELS, 1'b0, '0);
    endtask

    // Corner values of a 16-bit signed field.
    function automatic logic [15:0] corner_value(input int k);
        case (k)
            0:       return 16'h8000;
            1:       return 16'hFFFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Mostly ticks near the operating point so that the loop regulates rather than
    // saturates; the rest are stops, full-range values and corners.
    task automatic random_tick();
        int sel;
        int tgt;
        int cnt;

        sel = $urandom_range(99);
        if (sel < 55) begin
            tgt = int'($urandom_range(8000)) - 4000;
            cnt = tgt * int'(PPR) / (int'(TPS) * 60) + int'($urandom_range(6)) - 3;
            send_tick(cnt[15:0], tgt[15:0]);
        end else if (sel < 68) begin
            cnt = int'($urandom_range(200)) - 100;
            send_tick(cnt[15:0], '0);
        end else if (sel < 90) begin
            send_tick(16'($urandom), 16'($urandom));
        end else begin
            send_tick(corner_value($urandom_range(4)), corner_value($urandom_range(4)));
        end
    endtask

    // Main stimulus and verdict.
    initial begin
        int phase;
        int k;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values read back.
        reg_access(REG_KP_GAIN, 1'b0, '0);
        reg_access(REG_KI_GAIN, 1'b0, '0);
        reg_access(REG_DRIVE_LIMIT, 1'b0, '0);
        reg_access(REG_SWAP_CHANNELS, 1'b0, '0);

        // Directed ticks with reset gains: stop, small steps, exact match, extremes.
        send_tick(16'sd0, 16'sd0);
        send_tick(16'sd0, 16'sd1000);
        send_tick(16'sd10, 16'sd1000);
        send_tick(-16'sd10, -16'sd1000);
        send_tick(16'($signed(PPR)), 16'($signed(TPS * 60)));
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd0, 16'sh7FFF);
        send_tick(16'sd0, 16'sh8000);
        send_tick(-16'sd1, 16'sd1);
        send_tick(16'sd0, 16'sd0);

        // Zero limit holds the drive at zero whatever the error.
        drain_results();
        load_config(KP_GAIN_RST, KI_GAIN_RST, '0, 1'b0);
        send_tick(16'sd0, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd100, -16'sd5);

        // Largest gains and limit with the channels swapped.
        drain_results();
        load_config(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b1);
        send_tick(16'sd0, 16'sh7FFF);
        send_tick(16'sd0, 16'sh7FFF);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd0, 16'sd0);
        send_tick(-16'sd300, 16'sd100);

        // Random phases, each under its own register setting.
        for (phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: load_config(KP_GAIN_RST, KI_GAIN_RST, DRIVE_LIMIT_RST, 1'b0);
                1: load_config('0, '0, 15'h7FFF, 1'b1);
                2: load_config(16'hFFFF, 16'hFFFF, 15'h7FFF, 1'b0);
                3: load_config(GAIN_W'($urandom_range(8192)), GAIN_W'($urandom_range(4096)),
                               LIMIT_W'($urandom_range(32767)), 1'($urandom_range(1)));
                4: load_config(16'd4096, '0, 15'd1, 1'b1);
                default: load_config(GAIN_W'($urandom), GAIN_W'($urandom),
                                     LIMIT_W'($urandom), 1'($urandom));
            endcase
            for (k = 0; k < PHASE_TICKS; k++) begin
                // Once, the sender pauses mid-phase until the block has emptied.
                if (phase == 2 && k == PHASE_TICKS / 2) begin
                    drain_results();
                end
                random_tick();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_wheel_speed_pi_drive_top: done, clean");
        end else begin
            $display("tb_wheel_speed_pi_drive_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wspd_pkg.sv
rtl/wspd_cfg.sv
rtl/wspd_speed.sv
rtl/wspd_pi.sv
rtl/wheel_speed_pi_drive_top.sv
tb/sv/wspd_drive_checker.sv
tb/sv/tb_wheel_speed_pi_drive_top.sv
